@@ sv/pqe_pkg.sv @@
package pqe_pkg;

  // Fixed-point format of bounds and samples
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int X_W    = 21;  // bound / sample position, signed Q5.16
  localparam int N_W    = 11;  // interval count
  localparam int OP_W   = 2;   // method code
  localparam int ST_W   = 2;   // status code
  localparam int RES_W  = 64;  // result, signed Q32.32
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;

  // Datapath widths, sized from the worst case of 21-bit bounds
  localparam int D_W    = X_W + 1;       // b - a
  localparam int MA_W   = D_W;           // multiplier operand A (signed)
  localparam int MB_W   = 35;            // multiplier operand B (signed)
  localparam int MP_W   = MA_W + MB_W;   // full product
  localparam int F_W    = 39;            // one polynomial sample
  localparam int S_W    = 52;            // weighted sample sum
  localparam int SM_W   = S_W - 1;       // magnitude of the sum
  localparam int SPLIT  = 26;            // low half of the sum magnitude
  localparam int DIVD_W = SM_W + D_W - 1; // dividend of the serial divider
  localparam int DIVR_W = 13;            // divisor, up to 3 * (2^N_W - 1)
  localparam int QO_W   = D_W + 1;       // position offset floor(d*j/2n)

  localparam int N_MAX  = (1 << N_W) - 1;

  // Polynomial constants in Q19.16
  localparam logic signed [MB_W-1:0] POLY_K4 = MB_W'(4 * (1 << FRAC_BITS));
  localparam logic signed [MB_W-1:0] POLY_K1 = MB_W'(1 << FRAC_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_MID  = 2'd0,
    OP_TRAP = 2'd1,
    OP_SIMP = 2'd2,
    OP_BAD  = 2'd3
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BAD_OP = 2'd1,
    STAT_ZERO_N = 2'd2,
    STAT_SAT    = 2'd3
  } status_e;

  // Operand B selection of the shared multiplier
  typedef enum logic [2:0] {
    MOP_SQ    = 3'd0,  // B = A
    MOP_ADD4  = 3'd1,  // B = (P >>> F) + 4
    MOP_PLAIN = 3'd2,  // B = P >>> F
    MOP_SUB1  = 3'd3,  // B = (P >>> F) - 1
    MOP_RAW   = 3'd4   // B from the operand input
  } mul_op_e;

  typedef struct packed {
    logic init;
    logic step;
  } pos_cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

endpackage

@@ sv/pqe_mul_unit.sv @@
module pqe_mul_unit (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  pqe_pkg::mul_op_e                 op_i,
  input  logic signed [pqe_pkg::MA_W-1:0]  a_i,
  input  logic signed [pqe_pkg::MB_W-1:0]  b_i,
  output logic signed [pqe_pkg::MP_W-1:0]  p_o,
  output logic signed [pqe_pkg::F_W-1:0]   f_o
);

  logic signed [pqe_pkg::MP_W-1:0] p_q, p_d;
  logic signed [pqe_pkg::MP_W-1:0] p_sh;
  logic signed [pqe_pkg::MB_W-1:0] b_eff;
  logic signed [pqe_pkg::MP_W-1:0] a_ext, b_ext;

  // Floor of the previous product by 2^F feeds the next Horner step
  assign p_sh = p_q >>> pqe_pkg::FRAC_BITS;

  always_comb begin
    case (op_i)
      pqe_pkg::MOP_SQ:    b_eff = pqe_pkg::MB_W'(a_i);
      pqe_pkg::MOP_ADD4:  b_eff = p_sh[pqe_pkg::MB_W-1:0] + pqe_pkg::POLY_K4;
      pqe_pkg::MOP_PLAIN: b_eff = p_sh[pqe_pkg::MB_W-1:0];
      pqe_pkg::MOP_SUB1:  b_eff = p_sh[pqe_pkg::MB_W-1:0] - pqe_pkg::POLY_K1;
      pqe_pkg::MOP_RAW:   b_eff = b_i;
      default:            b_eff = b_i;
    endcase
  end

  assign a_ext = pqe_pkg::MP_W'(a_i);
  assign b_ext = pqe_pkg::MP_W'(b_eff);
  assign p_d   = a_ext * b_ext;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;
  assign f_o = p_sh[pqe_pkg::F_W-1:0];

endmodule

@@ sv/pqe_div_unit.sv @@
module pqe_div_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pqe_pkg::div_req_t             req_i,
  output logic                          done_o,
  output logic [pqe_pkg::DIVD_W-1:0]    quot_o,
  output logic [pqe_pkg::DIVR_W-1:0]    rem_o
);

  localparam int CNT_W = $clog2(pqe_pkg::DIVD_W + 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [pqe_pkg::DIVD_W-1:0]  sh_q;
  logic [pqe_pkg::DIVR_W-1:0]  rem_q, dvs_q;
  logic [pqe_pkg::DIVR_W:0]    trial, diff;
  logic                        ge;

  // One restoring step: bring down the next dividend bit
  assign trial = {rem_q, sh_q[pqe_pkg::DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  // Iteration control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(pqe_pkg::DIVD_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[pqe_pkg::DIVR_W-1:0] : trial[pqe_pkg::DIVR_W-1:0];
      sh_q  <= {sh_q[pqe_pkg::DIVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/pqe_pos_gen.sv @@
module pqe_pos_gen (
  input  logic                            clk_i,
  input  pqe_pkg::pos_cmd_t               cmd_i,
  input  logic signed [pqe_pkg::QO_W-1:0] qd_i,
  input  logic [pqe_pkg::DIVR_W-1:0]      rd_i,
  input  logic [pqe_pkg::DIVR_W-1:0]      den_i,
  output logic signed [pqe_pkg::QO_W-1:0] q_o
);

  // Tracks floor(d*j / 2n) as quotient plus remainder, one half step per beat
  logic signed [pqe_pkg::QO_W-1:0] q_q;
  logic [pqe_pkg::DIVR_W-1:0]      r_q;
  logic [pqe_pkg::DIVR_W:0]        r_sum, r_wrap;
  logic                            carry;

  assign r_sum  = {1'b0, r_q} + {1'b0, rd_i};
  assign carry  = r_sum >= {1'b0, den_i};
  assign r_wrap = r_sum - {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      q_q <= '0;
      r_q <= '0;
    end else if (cmd_i.step) begin
      r_q <= carry ? r_wrap[pqe_pkg::DIVR_W-1:0] : r_sum[pqe_pkg::DIVR_W-1:0];
      q_q <= q_q + qd_i + pqe_pkg::QO_W'({1'b0, carry});
    end
  end

  assign q_o = q_q;

endmodule

@@ sv/polynomial_quadrature_engine.sv @@
// Integrates f(x) = x^5 + 4x^3 - x from a to b over n subintervals by composite
// midpoint (n samples), trapezoid or Simpson (n+1 samples), and returns the
// result in signed Q32.32 with a status code. Bounds are signed Q5.16; the
// interval count is clamped to MAX_INTERVALS, a zero count or method code 3
// returns 0 with an error status, and a final value outside 64 bits saturates.
// All intermediate widths cover the full 21-bit input range, so samples
// never overflow or saturate, though each Horner step floors its product.
// One request at a time: each sample makes four passes through the one
// shared multiplier, and the step and final scaling each take a pass
// through the bit-serial divider. Error requests skip both units. The
// input is refused while a request is in work; a finished result waits in
// the output register without holding up the next request. tdata bits
// 55:53 are ignored.
module polynomial_quadrature_engine #(
  parameter int MAX_INTERVALS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // lower_bound[20:0], upper_bound[41:21], interval_count[52:42], zero pad
  input  logic [pqe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode[1:0]
  input  logic [pqe_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // integral_value[63:0]
  output logic [pqe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [pqe_pkg::ST_W-1:0]           m_axis_tuser
);

  localparam int N_CAP = (MAX_INTERVALS > pqe_pkg::N_MAX) ? pqe_pkg::N_MAX : MAX_INTERVALS;
  localparam logic [pqe_pkg::DIVD_W-1:0] LIM_POS =
    pqe_pkg::DIVD_W'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic [pqe_pkg::DIVD_W-1:0] LIM_NEG =
    pqe_pkg::DIVD_W'(64'h8000_0000_0000_0000);

  typedef enum logic [13:0] {
    ST_IDLE = 14'h0001,
    ST_DDIV = 14'h0002,
    ST_ADV  = 14'h0004,
    ST_MUL0 = 14'h0008,
    ST_MUL1 = 14'h0010,
    ST_MUL2 = 14'h0020,
    ST_MUL3 = 14'h0040,
    ST_ACC  = 14'h0080,
    ST_SD0  = 14'h0100,
    ST_SD1  = 14'h0200,
    ST_SD2  = 14'h0400,
    ST_SD3  = 14'h0800,
    ST_FDIV = 14'h1000,
    ST_DONE = 14'h2000
  } state_e;

  state_e state_q, state_d;

  // Input fields
  logic signed [pqe_pkg::X_W-1:0]    a_in, b_in;
  logic [pqe_pkg::N_W-1:0]           n_in, n_eff;
  pqe_pkg::opcode_e                  op_in;
  logic signed [pqe_pkg::D_W-1:0]    d_in, d_neg_in;
  logic [pqe_pkg::D_W-2:0]           dmag_in;
  logic [pqe_pkg::DIVR_W-1:0]        den_in;

  // Request registers
  logic signed [pqe_pkg::X_W-1:0]    a_q, x_q, x_now;
  logic                              dneg_q;
  logic [pqe_pkg::D_W-2:0]           dmag_q;
  logic [pqe_pkg::N_W-1:0]           n_q, k_q, klast_q;
  pqe_pkg::opcode_e                  op_q;
  logic [pqe_pkg::DIVR_W-1:0]        den_q, rd_q;
  logic signed [pqe_pkg::QO_W-1:0]   qd_q;
  logic                              pend_q;
  logic [1:0]                        ws_q, ws_next;
  logic signed [pqe_pkg::S_W-1:0]    s_q, addend;
  logic [pqe_pkg::SM_W-1:0]          smag_q;
  logic                              sneg_q;
  logic signed [pqe_pkg::MP_W-1:0]   plo_q;
  logic [pqe_pkg::RES_W-1:0]         res_q;
  pqe_pkg::status_e                  stat_q;
  logic                              m_valid_q;
  logic [pqe_pkg::OUT_TDATA_W-1:0]   m_data_q;
  pqe_pkg::status_e                  m_user_q;

  // Shared units
  logic                              mul_en;
  pqe_pkg::mul_op_e                  mul_op;
  logic signed [pqe_pkg::MA_W-1:0]   mul_a;
  logic signed [pqe_pkg::MB_W-1:0]   mul_b;
  logic signed [pqe_pkg::MP_W-1:0]   mul_p;
  logic signed [pqe_pkg::F_W-1:0]    mul_f;
  pqe_pkg::pos_cmd_t                 pos_cmd;
  logic signed [pqe_pkg::QO_W-1:0]   pos_q;
  pqe_pkg::div_req_t                 div_req;
  logic                              div_done;
  logic [pqe_pkg::DIVD_W-1:0]        div_quot;
  logic [pqe_pkg::DIVR_W-1:0]        div_rem;

  // Derived values
  logic [pqe_pkg::QO_W-2:0]          qm;
  logic signed [pqe_pkg::QO_W-1:0]   qd_calc;
  logic [pqe_pkg::DIVR_W-1:0]        rd_calc, nc;
  logic [pqe_pkg::DIVD_W-1:0]        prod, qq;
  logic                              rneg, sat;
  logic                              in_beat, out_load, bad_req;

  // Unpack the input beat
  assign a_in     = s_axis_tdata[20:0];
  assign b_in     = s_axis_tdata[41:21];
  assign n_in     = s_axis_tdata[52:42];
  assign op_in    = pqe_pkg::opcode_e'(s_axis_tuser);
  assign n_eff    = (32'(n_in) > 32'(N_CAP)) ? pqe_pkg::N_W'(N_CAP) : n_in;
  assign d_in     = pqe_pkg::D_W'(b_in) - pqe_pkg::D_W'(a_in);
  assign d_neg_in = -d_in;
  assign dmag_in  = d_in[pqe_pkg::D_W-1] ? d_neg_in[pqe_pkg::D_W-2:0] : d_in[pqe_pkg::D_W-2:0];
  assign den_in   = pqe_pkg::DIVR_W'({n_eff, 1'b0});
  assign bad_req  = (op_in == pqe_pkg::OP_BAD) || (n_in == '0);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Current sample position
  assign x_now = pqe_pkg::X_W'(pqe_pkg::QO_W'(a_q) + pos_q);

  // Signed step per half interval from the unsigned quotient
  assign qm      = div_quot[pqe_pkg::QO_W-2:0];
  assign qd_calc = dneg_q ? ((div_rem != '0) ? -pqe_pkg::QO_W'(qm) - 1'sb1
                                             : -pqe_pkg::QO_W'(qm))
                          : pqe_pkg::QO_W'(qm);
  assign rd_calc = (dneg_q && (div_rem != '0)) ? den_q - div_rem : div_rem;

  // Sample weight as a shift: midpoint and ends 1, trapezoid 2, Simpson 4 and 2
  always_comb begin
    ws_next = 2'd0;
    if (op_q != pqe_pkg::OP_MID && k_q != '0 && k_q != klast_q) begin
      if (op_q == pqe_pkg::OP_TRAP) begin
        ws_next = 2'd1;
      end else begin
        ws_next = k_q[0] ? 2'd2 : 2'd1;
      end
    end
  end

  assign addend = pqe_pkg::S_W'(mul_f) <<< ws_q;

  // Final divisor n*c and the product |S|*|d|
  always_comb begin
    case (op_q)
      pqe_pkg::OP_MID:  nc = pqe_pkg::DIVR_W'(n_q);
      pqe_pkg::OP_TRAP: nc = pqe_pkg::DIVR_W'({n_q, 1'b0});
      pqe_pkg::OP_SIMP: nc = pqe_pkg::DIVR_W'({n_q, 1'b0}) + pqe_pkg::DIVR_W'(n_q);
      default:          nc = pqe_pkg::DIVR_W'(n_q);
    endcase
  end

  assign prod = (pqe_pkg::DIVD_W'($unsigned(mul_p)) << pqe_pkg::SPLIT)
              + pqe_pkg::DIVD_W'($unsigned(plo_q));

  // Floor toward minus infinity, then saturate
  assign rneg = sneg_q ^ dneg_q;
  assign qq   = div_quot + pqe_pkg::DIVD_W'(rneg && (div_rem != '0));
  assign sat  = rneg ? (qq > LIM_NEG) : (qq > LIM_POS);

  // Sequencer
  always_comb begin
    state_d          = state_q;
    mul_en           = 1'b0;
    mul_op           = pqe_pkg::MOP_RAW;
    mul_a            = '0;
    mul_b            = '0;
    pos_cmd          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = pqe_pkg::DIVD_W'(dmag_in);
    div_req.divisor  = den_in;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (bad_req) begin
            state_d = ST_DONE;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_DDIV;
          end
        end
      end
      ST_DDIV: begin
        if (div_done) begin
          pos_cmd.init = 1'b1;
          state_d      = (op_q == pqe_pkg::OP_MID) ? ST_ADV : ST_MUL0;
        end
      end
      ST_ADV: begin
        pos_cmd.step = 1'b1;
        state_d      = ST_MUL0;
      end
      ST_MUL0: begin
        mul_en       = 1'b1;
        mul_op       = pqe_pkg::MOP_SQ;
        mul_a        = pqe_pkg::MA_W'(x_now);
        pos_cmd.step = (k_q != klast_q);
        state_d      = ST_MUL1;
      end
      ST_MUL1: begin
        mul_en       = 1'b1;
        mul_op       = pqe_pkg::MOP_ADD4;
        mul_a        = pqe_pkg::MA_W'(x_q);
        pos_cmd.step = (k_q != klast_q);
        state_d      = ST_MUL2;
      end
      ST_MUL2: begin
        mul_en  = 1'b1;
        mul_op  = pqe_pkg::MOP_PLAIN;
        mul_a   = pqe_pkg::MA_W'(x_q);
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_en  = 1'b1;
        mul_op  = pqe_pkg::MOP_SUB1;
        mul_a   = pqe_pkg::MA_W'(x_q);
        state_d = (k_q == klast_q) ? ST_ACC : ST_MUL0;
      end
      ST_ACC: begin
        state_d = ST_SD0;
      end
      ST_SD0: begin
        state_d = ST_SD1;
      end
      ST_SD1: begin
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, dmag_q});
        mul_b   = $signed(pqe_pkg::MB_W'(smag_q[pqe_pkg::SPLIT-1:0]));
        state_d = ST_SD2;
      end
      ST_SD2: begin
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, dmag_q});
        mul_b   = $signed(pqe_pkg::MB_W'(smag_q[pqe_pkg::SM_W-1:pqe_pkg::SPLIT]));
        state_d = ST_SD3;
      end
      ST_SD3: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = nc;
        state_d          = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      pend_q    <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_DDIV: begin
          k_q    <= '0;
          pend_q <= 1'b0;
        end
        ST_MUL0: pend_q <= 1'b0;
        ST_MUL3: begin
          pend_q <= 1'b1;
          if (k_q != klast_q) begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_ACC:  pend_q <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      a_q    <= a_in;
      dneg_q <= d_in[pqe_pkg::D_W-1];
      dmag_q <= dmag_in;
      n_q    <= n_eff;
      op_q   <= op_in;
      den_q  <= den_in;
      res_q  <= '0;
      stat_q <= (op_in == pqe_pkg::OP_BAD) ? pqe_pkg::STAT_BAD_OP : pqe_pkg::STAT_ZERO_N;
    end
    case (state_q)
      ST_DDIV: begin
        if (div_done) begin
          qd_q    <= qd_calc;
          rd_q    <= rd_calc;
          klast_q <= (op_q == pqe_pkg::OP_MID) ? n_q - 1'b1 : n_q;
          s_q     <= '0;
        end
      end
      ST_MUL0: begin
        x_q <= x_now;
        if (pend_q) begin
          s_q <= s_q + addend;
        end
      end
      ST_MUL3: ws_q <= ws_next;
      ST_ACC:  s_q  <= s_q + addend;
      ST_SD0: begin
        sneg_q <= s_q[pqe_pkg::S_W-1];
        smag_q <= s_q[pqe_pkg::S_W-1] ? pqe_pkg::SM_W'(-s_q) : pqe_pkg::SM_W'(s_q);
      end
      ST_SD2:  plo_q <= mul_p;
      ST_FDIV: begin
        if (div_done) begin
          if (sat) begin
            res_q  <= rneg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            stat_q <= pqe_pkg::STAT_SAT;
          end else begin
            res_q  <= rneg ? -qq[pqe_pkg::RES_W-1:0] : qq[pqe_pkg::RES_W-1:0];
            stat_q <= pqe_pkg::STAT_OK;
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_data_q <= res_q;
      m_user_q <= stat_q;
    end
  end

  pqe_mul_unit u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .op_i  (mul_op),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p),
    .f_o   (mul_f)
  );

  pqe_pos_gen u_pos (
    .clk_i (clk_i),
    .cmd_i (pos_cmd),
    .qd_i  (qd_q),
    .rd_i  (rd_q),
    .den_i (den_q),
    .q_o   (pos_q)
  );

  pqe_div_unit u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
